// File: rtl/core/assert_macros.svh
// Assertion macros shared by the palette match RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PNCM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PNCM_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PNCM_ASSERT_IMP(name, clk, rstn, ante, cons, msg)
`define PNCM_ASSERT_NXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/core/pncm_pkg.sv
// Types and constants shared by the palette match modules.
`default_nettype none
package pncm_pkg;

    localparam int PAL_ENTRIES_DEF = 256;
    localparam int IDX_W           = 8;
    localparam int CH_W            = 8;
    localparam int HSV_W           = 3 * CH_W;
    localparam int DIST_W          = 18;
    localparam int DIV_W           = 16;
    localparam int CNT_W           = 4;

    localparam logic [CH_W-1:0] HUE_OFF_R  = 8'd0;
    localparam logic [CH_W-1:0] HUE_OFF_G  = 8'd85;
    localparam logic [CH_W-1:0] HUE_OFF_B  = 8'd171;
    localparam logic [5:0]      HUE_STEP   = 6'd43;
    localparam logic [CH_W-1:0] SECTOR_LEN = 8'd60;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] h;
        logic [CH_W-1:0] s;
        logic [CH_W-1:0] v;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // Travels with each color through the HSV to RGB pipeline.
    typedef struct packed {
        logic             want;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

    typedef enum logic {
        CV_IDLE,
        CV_RUN
    } cvt_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_WANT,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } core_state_t;

endpackage
`default_nettype wire

// File: rtl/core/pncm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pncm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/pncm_rgb2hsv.sv
// RGB to HSV converter with two shift-subtract dividers run side by side.
`default_nettype none
module pncm_rgb2hsv (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire pncm_pkg::rgb_t rgb,
    output logic               done,
    output pncm_pkg::hsv_t     hsv
);
    import pncm_pkg::*;

    cvt_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [CH_W-1:0]   mx_reg, off_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  ns_reg, nh_reg;
    logic [CH_W-1:0]   rs_reg, rh_reg;

    logic [CH_W-1:0]   mx, mn, off;
    logic signed [CH_W:0] diff;
    logic              neg;
    logic [CH_W-1:0]   mag;
    logic [CH_W:0]     trial_s, trial_h;
    logic              ge_s, ge_h;
    logic [CH_W-1:0]   sat, q_h;

    always_comb begin
        mx = rgb.r;
        mn = rgb.r;
        if (rgb.g < mn) mn = rgb.g;
        if (rgb.b < mn) mn = rgb.b;
        if (rgb.g > mx) mx = rgb.g;
        if (rgb.b > mx) mx = rgb.b;
        if (mx == rgb.r) begin
            off  = HUE_OFF_R;
            diff = $signed({1'b0, rgb.g}) - $signed({1'b0, rgb.b});
        end else if (mx == rgb.g) begin
            off  = HUE_OFF_G;
            diff = $signed({1'b0, rgb.b}) - $signed({1'b0, rgb.r});
        end else begin
            off  = HUE_OFF_B;
            diff = $signed({1'b0, rgb.r}) - $signed({1'b0, rgb.g});
        end
        neg = diff[CH_W];
        mag = neg ? CH_W'(-diff) : diff[CH_W-1:0];
    end

    assign trial_s = {rs_reg, ns_reg[DIV_W-1]};
    assign trial_h = {rh_reg, nh_reg[DIV_W-1]};
    assign ge_s    = trial_s >= {1'b0, mx_reg};
    assign ge_h    = trial_h >= {1'b0, mx_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CV_IDLE: if (start) state_next = CV_RUN;
            CV_RUN:  if (cnt_reg == {CNT_W{1'b1}}) state_next = CV_IDLE;
            default: state_next = CV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == CV_RUN) && (cnt_reg == {CNT_W{1'b1}});
            cnt_reg   <= (state_reg == CV_RUN) ? cnt_reg + 1'b1 : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == CV_IDLE && start) begin
            mx_reg  <= mx;
            off_reg <= off;
            neg_reg <= neg;
            ns_reg  <= (DIV_W'(mx - mn) << CH_W) - DIV_W'(mx - mn);
            nh_reg  <= DIV_W'(mag) * DIV_W'(HUE_STEP);
            rs_reg  <= '0;
            rh_reg  <= '0;
        end else if (state_reg == CV_RUN) begin
            rs_reg <= ge_s ? CH_W'(trial_s - {1'b0, mx_reg}) : trial_s[CH_W-1:0];
            rh_reg <= ge_h ? CH_W'(trial_h - {1'b0, mx_reg}) : trial_h[CH_W-1:0];
            ns_reg <= {ns_reg[DIV_W-2:0], ge_s};
            nh_reg <= {nh_reg[DIV_W-2:0], ge_h};
        end
    end

    // A black input has no defined ratio; both saturation and hue are zero.
    assign sat   = (mx_reg == '0) ? '0 : ns_reg[CH_W-1:0];
    assign q_h   = nh_reg[CH_W-1:0];
    assign hsv.v = mx_reg;
    assign hsv.s = sat;
    assign hsv.h = (sat == '0) ? '0 : (neg_reg ? off_reg - q_h : off_reg + q_h);
    assign done  = done_reg;
endmodule
`default_nettype wire

// File: rtl/core/pncm_hsv2rgb.sv
// Three-stage HSV to RGB pipeline that carries a tag with each color.
`default_nettype none
module pncm_hsv2rgb (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire pncm_pkg::hsv_t in_hsv,
    input  wire pncm_pkg::tag_t in_tag,
    output logic                out_valid,
    output pncm_pkg::rgb_t      out_rgb,
    output pncm_pkg::tag_t      out_tag
);
    import pncm_pkg::*;

    logic [2:0]       sec;
    logic [5:0]       rem;
    logic [9:0]       f17;
    logic [CH_W-1:0]  f;
    logic [15:0]      sf, stf;

    logic             v1_reg, v2_reg, v3_reg;
    tag_t             t1_reg, t2_reg, t3_reg;
    logic [2:0]       sec1_reg, sec2_reg;
    logic             gray1_reg, gray2_reg;
    logic [CH_W-1:0]  val1_reg, val2_reg;
    logic [CH_W:0]    oms_reg, qk_reg, tk_reg;
    logic [CH_W-1:0]  p_reg, q_reg, t_reg;
    rgb_t             rgb_reg;
    rgb_t             sel;
    logic [16:0]      pp, qp, tp;

    // Stage one: sector, fraction and the saturation products.
    always_comb begin
        if (in_hsv.h < SECTOR_LEN) begin
            sec = 3'd0; rem = 6'(in_hsv.h);
        end else if (in_hsv.h < 8'd120) begin
            sec = 3'd1; rem = 6'(in_hsv.h - 8'd60);
        end else if (in_hsv.h < 8'd180) begin
            sec = 3'd2; rem = 6'(in_hsv.h - 8'd120);
        end else if (in_hsv.h < 8'd240) begin
            sec = 3'd3; rem = 6'(in_hsv.h - 8'd180);
        end else begin
            sec = 3'd4; rem = 6'(in_hsv.h - 8'd240);
        end
        // rem * 255 / 60 is exactly rem * 17 / 4.
        f17 = {rem, 4'b0000} + 10'(rem);
        f   = f17[9:2];
        sf  = 16'(in_hsv.s) * 16'(f);
        stf = 16'(in_hsv.s) * 16'(9'd256 - {1'b0, f});
    end

    // Stage two: value products.
    assign pp = 17'(val1_reg) * 17'(oms_reg);
    assign qp = 17'(val1_reg) * 17'(qk_reg);
    assign tp = 17'(val1_reg) * 17'(tk_reg);

    // Stage three: sector select.
    always_comb begin
        if (gray2_reg) begin
            sel = '{r: val2_reg, g: val2_reg, b: val2_reg};
        end else begin
            case (sec2_reg)
                3'd0:    sel = '{r: val2_reg, g: t_reg,    b: p_reg};
                3'd1:    sel = '{r: q_reg,    g: val2_reg, b: p_reg};
                3'd2:    sel = '{r: p_reg,    g: val2_reg, b: t_reg};
                3'd3:    sel = '{r: p_reg,    g: q_reg,    b: val2_reg};
                3'd4:    sel = '{r: t_reg,    g: p_reg,    b: val2_reg};
                default: sel = '{r: val2_reg, g: p_reg,    b: q_reg};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg    <= in_tag;
        sec1_reg  <= sec;
        gray1_reg <= (in_hsv.s == '0);
        val1_reg  <= in_hsv.v;
        oms_reg   <= 9'd256 - {1'b0, in_hsv.s};
        qk_reg    <= 9'd256 - {1'b0, sf[15:8]};
        tk_reg    <= 9'd256 - {1'b0, stf[15:8]};

        t2_reg    <= t1_reg;
        sec2_reg  <= sec1_reg;
        gray2_reg <= gray1_reg;
        val2_reg  <= val1_reg;
        p_reg     <= pp[15:8];
        q_reg     <= qp[15:8];
        t_reg     <= tp[15:8];

        t3_reg    <= t2_reg;
        rgb_reg   <= sel;
    end

    assign out_valid = v3_reg;
    assign out_rgb   = rgb_reg;
    assign out_tag   = t3_reg;
endmodule
`default_nettype wire

// File: rtl/core/palette_nearest_color_match_core.sv
// Top level of the nearest palette color match block.
//
// Input items arrive on the s_ stream: s_tuser selects a load (0) or a query (1),
// s_tdata carries the entry index and the RGB color. A load converts the color
// to HSV and writes it into the palette; it produces no result item. A query
// converts its color to HSV and back, then streams every palette entry through
// the HSV to RGB pipeline, one per cycle, and returns on the m_ stream the first
// index with the smallest squared RGB distance.
// A load runs the 16-step dividers of the converter, then writes the palette.
// A query spends most of its time in the palette scan, which makes one memory
// read per cycle. One item is in work at a time; s_tready is high while the
// block is idle.
// The result sits in an output register, so a new item is taken while a
// result waits; if a second query finishes before the receiver takes the
// first result, the block holds until m_tready frees the register.
// After reset the palette reads as all black (every entry invalid) and no
// result is pending.
`default_nettype none
module palette_nearest_color_match_core #(
    parameter int PALETTE_ENTRIES = pncm_pkg::PAL_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // entry_index, red, green, blue
    input  wire logic [0:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // best_index
);
    import pncm_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(PALETTE_ENTRIES);

    core_state_t          state_reg, state_next;
    logic                 op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [AW-1:0]        cnt_reg;
    hsv_t                 hsv_reg;
    logic [PALETTE_ENTRIES-1:0] vld_reg;

    logic                 in_acc;
    rgb_t                 in_rgb;
    logic                 cv_done;
    hsv_t                 cv_hsv;

    logic                 ram_we;
    logic [AW-1:0]        raddr;
    logic [HSV_W-1:0]     ram_rdata;
    logic                 rd_en;
    logic                 rd_vld_reg, rd_last_reg, rd_ent_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic                 h_in_vld;
    hsv_t                 h_in_hsv;
    tag_t                 h_in_tag;
    logic                 h_out_vld;
    rgb_t                 h_out_rgb;
    tag_t                 h_out_tag;

    rgb_t                 want_reg;
    logic                 d1_vld_reg;
    tag_t                 d1_tag_reg;
    logic [15:0]          sqr_reg, sqg_reg, sqb_reg;
    logic signed [CH_W:0] dr, dg, db;
    logic signed [17:0]   pr, pg, pb;
    logic [DIST_W-1:0]    dsum;
    logic [DIST_W-1:0]    best_d_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 m_tvalid_reg;
    logic [IDX_W-1:0]     m_tdata_reg;
    logic                 out_load;
    logic                 scan_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_rgb   = '{r: s_tdata[15:8], g: s_tdata[23:16], b: s_tdata[31:24]};

    pncm_rgb2hsv u_cvt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_acc),
        .rgb     (in_rgb),
        .done    (cv_done),
        .hsv     (cv_hsv)
    );

    assign ram_we = (state_reg == ST_CONV) && cv_done && (op_reg == OP_LOAD) &&
                    ({1'b0, idx_reg} < 9'(PALETTE_ENTRIES));
    assign rd_en  = (state_reg == ST_WANT) || (state_reg == ST_SCAN);
    assign raddr  = (state_reg == ST_WANT) ? '0 : cnt_reg;

    pncm_ram #(
        .WIDTH (HSV_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (cv_hsv),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // The query color enters the pipeline first, then the palette entries.
    assign h_in_vld = (state_reg == ST_WANT) || rd_vld_reg;
    always_comb begin
        if (state_reg == ST_WANT) begin
            h_in_hsv = hsv_reg;
            h_in_tag = '{want: 1'b1, last: 1'b0, idx: '0};
        end else begin
            h_in_hsv = rd_ent_vld_reg ? hsv_t'(ram_rdata) : '0;
            h_in_tag = '{want: 1'b0, last: rd_last_reg, idx: rd_idx_reg};
        end
    end

    pncm_hsv2rgb u_h2r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h_in_vld),
        .in_hsv    (h_in_hsv),
        .in_tag    (h_in_tag),
        .out_valid (h_out_vld),
        .out_rgb   (h_out_rgb),
        .out_tag   (h_out_tag)
    );

    assign dr   = $signed({1'b0, h_out_rgb.r}) - $signed({1'b0, want_reg.r});
    assign dg   = $signed({1'b0, h_out_rgb.g}) - $signed({1'b0, want_reg.g});
    assign db   = $signed({1'b0, h_out_rgb.b}) - $signed({1'b0, want_reg.b});
    assign pr   = dr * dr;
    assign pg   = dg * dg;
    assign pb   = db * db;
    assign dsum = DIST_W'(sqr_reg) + DIST_W'(sqg_reg) + DIST_W'(sqb_reg);

    assign scan_end = d1_vld_reg && d1_tag_reg.last;
    assign out_load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_CONV;
            ST_CONV:   if (cv_done) state_next = (op_reg == OP_QUERY) ? ST_WANT : ST_IDLE;
            ST_WANT:   state_next = ST_SCAN;
            ST_SCAN:   if (cnt_reg == AW'(PALETTE_ENTRIES - 1)) state_next = ST_DRAIN;
            ST_DRAIN:  if (scan_end) state_next = ST_RESULT;
            ST_RESULT: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            d1_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            d1_vld_reg <= h_out_vld && !h_out_tag.want;
            if (ram_we) begin
                vld_reg[idx_reg[AW-1:0]] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_reg  <= s_tuser[0];
            idx_reg <= s_tdata[7:0];
        end
        if (state_reg == ST_CONV && cv_done) begin
            hsv_reg <= cv_hsv;
        end
        if (state_reg == ST_WANT) begin
            cnt_reg    <= AW'(1);
            best_d_reg <= {DIST_W{1'b1}};
        end else if (state_reg == ST_SCAN) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        rd_idx_reg     <= IDX_W'(raddr);
        rd_last_reg    <= (raddr == AW'(PALETTE_ENTRIES - 1));
        rd_ent_vld_reg <= vld_reg[raddr];

        if (h_out_vld && h_out_tag.want) begin
            want_reg <= h_out_rgb;
        end
        d1_tag_reg <= h_out_tag;
        sqr_reg    <= pr[15:0];
        sqg_reg    <= pg[15:0];
        sqb_reg    <= pb[15:0];

        if (d1_vld_reg && (dsum < best_d_reg)) begin
            best_d_reg   <= dsum;
            best_idx_reg <= d1_tag_reg.idx;
        end
        if (out_load) begin
            m_tdata_reg <= best_idx_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PNCM_ASSERT_IMP(a_we_in_conv, aclk, aresetn, ram_we, state_reg == ST_CONV,
        "palette written outside conversion")
    `PNCM_ASSERT_IMP(a_end_in_drain, aclk, aresetn, scan_end, state_reg == ST_DRAIN,
        "last palette entry compared outside drain")
    `PNCM_ASSERT_IMP(a_pipe_idle, aclk, aresetn,
        (state_reg == ST_IDLE || state_reg == ST_CONV), !rd_vld_reg && !d1_vld_reg,
        "scan pipeline busy while idle or converting")
    `PNCM_ASSERT_NXT(a_load_shows, aclk, aresetn, out_load,
        m_tvalid && m_tdata == $past(best_idx_reg),
        "result register not loaded with best index")
endmodule
`default_nettype wire
